### rtl/core/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg: shared types and constants for the radix digit converter
// Widths of the value path, digit stack sizing, divider status struct and sequencer states.
// ----------------------------------------------------------------------------
package rdc_pkg;

	// Width of the integer to convert
	localparam int VALUE_BITS  = 31;
	// Radix and digit width
	localparam int RADIX_W     = 8;
	// Digit stack holds one digit per value bit, plus one spare entry
	localparam int STACK_DEPTH = VALUE_BITS + 1;
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	// Divider step counter, must hold VALUE_BITS itself
	localparam int DIV_CNT_W   = $clog2(VALUE_BITS + 1);

	// Status returned by the shared divider
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Sequencer states, one-hot
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DIV  = 5'b00010,
		S_RD   = 5'b00100,
		S_OUT  = 5'b01000,
		S_ERR  = 5'b10000
	} state_t;

endpackage

### rtl/core/rdc_divider.sv
// ----------------------------------------------------------------------------
// rdc_divider: iterative restoring divider
// Divides a VALUE_BITS dividend by an 8-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rdc_divider
	import rdc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [RADIX_W-1:0]    divisor,
	output div_stat_t             stat,
	output logic [VALUE_BITS-1:0] quotient,
	output logic [RADIX_W-1:0]    remainder
);

	logic [VALUE_BITS-1:0] quo_q;
	logic [RADIX_W-1:0]    rem_q;
	logic [RADIX_W-1:0]    dvs_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [RADIX_W:0]      trial;
	logic [RADIX_W:0]      diff;
	logic                  qbit;
	logic [RADIX_W-1:0]    rem_nxt;

	// One restoring step: shift in next dividend bit, trial subtract
	always_comb begin
		trial   = {rem_q, quo_q[VALUE_BITS-1]};
		diff    = trial - {1'b0, dvs_q};
		qbit    = (trial >= {1'b0, dvs_q});
		rem_nxt = qbit ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], qbit};
			rem_q <= rem_nxt;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### rtl/core/rdc_digit_stack.sv
// ----------------------------------------------------------------------------
// rdc_digit_stack: digit storage
// One write port and one registered read port; contents undefined until written.
// ----------------------------------------------------------------------------
module rdc_digit_stack
	import rdc_pkg::*;
(
	input  logic               clk,
	input  logic               we,
	input  logic [PTR_W-1:0]   waddr,
	input  logic [RADIX_W-1:0] wdata,
	input  logic               re,
	input  logic [PTR_W-1:0]   raddr,
	output logic [RADIX_W-1:0] rdata
);

	logic [RADIX_W-1:0] mem_q [STACK_DEPTH];
	logic [RADIX_W-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/radix_digit_converter.sv
// ----------------------------------------------------------------------------
// radix_digit_converter: integer to base-N digit conversion
// Emits the digits of value in base radix, most significant first.
// ----------------------------------------------------------------------------
// One request carries value and radix. The block divides repeatedly by the
// radix in a shared bit-serial divider, stacking the remainders, then pops
// them out one result per digit with last set on the final one. Zero gives a
// single zero digit; a radix below two gives one result with error and last
// set and digit zero. The block takes one request at a time and holds
// in_ready low until the final digit is accepted. The divider yields one
// quotient bit a cycle and its remainder is stacked when it reports done;
// each digit is then read from the stack and held on the output until accepted.
// ----------------------------------------------------------------------------
module radix_digit_converter
	import rdc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [RADIX_W-1:0]    radix,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [RADIX_W-1:0]    digit,
	output logic                  last,
	output logic                  error
);

	state_t                state_q;
	logic [PTR_W-1:0]      ptr_q;
	logic [RADIX_W-1:0]    radix_q;

	logic                  in_acc;
	logic                  out_acc;
	logic                  bad_radix;
	logic                  div_start;
	logic [VALUE_BITS-1:0] div_dividend;
	logic [RADIX_W-1:0]    div_divisor;
	div_stat_t             div_stat;
	logic [VALUE_BITS-1:0] div_quo;
	logic [RADIX_W-1:0]    div_rem;
	logic                  stk_we;
	logic                  stk_re;
	logic [RADIX_W-1:0]    stk_rdata;
	logic                  div_final;

	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign bad_radix = (radix[RADIX_W-1:1] == '0);

	// Conversion ends when the quotient is zero or the stack is full
	assign div_final = (div_quo == '0) || (ptr_q == PTR_W'(STACK_DEPTH - 1));

	// Divider start: first digit from the request, later ones from the quotient
	always_comb begin
		div_start    = 1'b0;
		div_dividend = div_quo;
		div_divisor  = radix_q;
		if (state_q == S_IDLE) begin
			div_start    = in_acc && !bad_radix;
			div_dividend = value;
			div_divisor  = radix;
		end else if (state_q == S_DIV) begin
			div_start = div_stat.done && !div_final;
		end
	end

	assign stk_we = (state_q == S_DIV) && div_stat.done;
	assign stk_re = (state_q == S_RD);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q   <= '0;
			radix_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						radix_q <= radix;
						ptr_q   <= '0;
						state_q <= bad_radix ? S_ERR : S_DIV;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						if (div_final) begin
							state_q <= S_RD;
						end else begin
							ptr_q <= ptr_q + 1'b1;
						end
					end
				end
				S_RD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						if (ptr_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q   <= ptr_q - 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_ERR: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	rdc_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	rdc_digit_stack u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (ptr_q),
		.wdata (div_rem),
		.re    (stk_re),
		.raddr (ptr_q),
		.rdata (stk_rdata)
	);

	// Result outputs, all from registers
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT) || (state_q == S_ERR);
	assign error     = (state_q == S_ERR);
	assign last      = (state_q == S_ERR) || (ptr_q == '0);
	assign digit     = (state_q == S_ERR) ? '0 : stk_rdata;

	// Never take a request while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request accepted while result pending");

	// Divider is only started when idle or just finished
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider restarted while busy");

	// The final digit returns the block to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last) |=> in_ready)
		else $error("not idle after final digit");

	// Stack is only written while converting
	a_stack_wr: assert property (@(posedge clk) disable iff (!arst_n)
		stk_we |-> (state_q == S_DIV) && !out_valid)
		else $error("stack write outside conversion");

endmodule

### tb/sv/radix_digit_converter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix_digit_converter_tb: self-checking bench for the radix digit converter
// Feeds value/radix requests through a valid/ready driver, predicts the digit
// sequence of each accepted request and checks every result in order.
// ----------------------------------------------------------------------------
module radix_digit_converter_tb;
	import rdc_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_REQS = 187;
	localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

	typedef struct {
		logic [VALUE_BITS-1:0] value;
		logic [RADIX_W-1:0]    radix;
	} conv_req_t;

	typedef struct {
		logic [RADIX_W-1:0] digit;
		logic               last;
		logic               error;
	} digit_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [VALUE_BITS-1:0] value = '0;
	logic [RADIX_W-1:0]    radix = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [RADIX_W-1:0]    digit;
	logic                  last;
	logic                  error;

	conv_req_t     req_queue[$];
	digit_result_t expected_digits[$];
	logic          req_taken = 1'b0;
	int            reqs_total = 0;
	int            reqs_accepted = 0;
	int            mismatches = 0;
	int            cycles = 0;

	radix_digit_converter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.radix    (radix),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.digit    (digit),
		.last     (last),
		.error    (error)
	);

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic add_req(input logic [VALUE_BITS-1:0] v, input logic [RADIX_W-1:0] r);
		conv_req_t q;
		q.value = v;
		q.radix = r;
		req_queue.push_back(q);
	endtask

	// Digits of v in base r, most significant first; bad radix gives one error result
	task automatic predict_digits(input logic [VALUE_BITS-1:0] v,
	                              input logic [RADIX_W-1:0] r);
		logic [VALUE_BITS-1:0] rem;
		logic [RADIX_W-1:0]    stack [STACK_DEPTH];
		int                    n;
		digit_result_t         d;
		if (r < 2) begin
			d.digit = '0;
			d.last  = 1'b1;
			d.error = 1'b1;
			expected_digits.push_back(d);
		end else begin
			rem = v;
			n   = 0;
			do begin
				stack[n] = RADIX_W'(rem % VALUE_BITS'(r));
				n++;
				rem = rem / VALUE_BITS'(r);
			end while (rem != 0 && n < STACK_DEPTH);
			for (int k = n - 1; k >= 0; k--) begin
				d.digit = stack[k];
				d.last  = (k == 0);
				d.error = 1'b0;
				expected_digits.push_back(d);
			end
		end
	endtask

	// Idle chance in percent per side: sender-heavy, receiver-heavy, then none
	function automatic int send_idle_pct();
		int ph;
		ph = (reqs_total == 0) ? 0 : (reqs_accepted * 3) / reqs_total;
		return (ph == 0) ? 16 : (ph == 1) ? 88 : 0;
	endfunction

	function automatic int recv_idle_pct();
		int ph;
		ph = (reqs_total == 0) ? 0 : (reqs_accepted * 3) / reqs_total;
		return (ph == 0) ? 88 : (ph == 1) ? 16 : 0;
	endfunction

	// Request driver: holds valid and payload until the request is taken
	always @(negedge clk) begin
		conv_req_t q;
		if (arst_n) begin
			if (!in_valid || req_taken) begin
				if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
					q = req_queue.pop_front();
					in_valid <= 1'b1;
					value    <= q.value;
					radix    <= q.radix;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct());
		end
	end

	// Monitor: predict on request accept, check on result accept
	always @(posedge clk) begin
		digit_result_t e;
		req_taken <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			predict_digits(value, radix);
			reqs_accepted <= reqs_accepted + 1;
		end
		if (out_valid && out_ready) begin
			if (expected_digits.size() == 0) begin
				report_mismatch($sformatf("unexpected result digit=%0d last=%b error=%b",
				                          digit, last, error));
			end else begin
				e = expected_digits.pop_front();
				if (digit !== e.digit || last !== e.last || error !== e.error)
					report_mismatch($sformatf(
						"digit=%0d last=%b error=%b, expected digit=%0d last=%b error=%b",
						digit, last, error, e.digit, e.last, e.error));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("radix_digit_converter_tb failed");
			$finish;
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int                    sel;
		logic [VALUE_BITS-1:0] v;
		logic [RADIX_W-1:0]    r;
		longint unsigned       p;

		// Directed: zero, bad radix, extremes, digit boundaries
		add_req('0, 8'd10);
		add_req('0, 8'd2);
		add_req('0, 8'd0);
		add_req(VALUE_BITS'(12345), 8'd1);
		add_req(VALUE_MAX, 8'd0);
		add_req(VALUE_MAX, 8'd1);
		add_req(VALUE_MAX, 8'd2);
		add_req(VALUE_MAX, 8'd255);
		add_req(VALUE_MAX, 8'd254);
		add_req(VALUE_MAX, 8'd3);
		add_req(VALUE_MAX, 8'd16);
		add_req(VALUE_BITS'(1), 8'd2);
		add_req(VALUE_BITS'(1), 8'd255);
		add_req(VALUE_BITS'(2), 8'd2);
		add_req(VALUE_BITS'(254), 8'd255);
		add_req(VALUE_BITS'(255), 8'd255);
		add_req(VALUE_BITS'(9), 8'd10);
		add_req(VALUE_BITS'(10), 8'd10);
		add_req(VALUE_BITS'(1000000000), 8'd10);
		add_req(VALUE_BITS'(32'h4000_0000), 8'd2);
		add_req(VALUE_BITS'(32'h2AAA_AAAA), 8'd2);
		add_req(VALUE_BITS'(32'h5555_5555), 8'd2);
		add_req(VALUE_BITS'(127), 8'd128);

		// Random mix: mostly good radixes, some boundaries, a few rejects
		repeat (RANDOM_REQS) begin
			sel = $urandom_range(99);
			r   = RADIX_W'($urandom_range(255, 2));
			v   = VALUE_BITS'($urandom());
			if (sel < 6) begin
				r = RADIX_W'($urandom_range(1));
			end else if (sel < 25) begin
				r = RADIX_W'($urandom_range(16, 2));
			end else if (sel < 45) begin
				v = VALUE_BITS'($urandom_range(int'(r) * int'(r)));
			end else if (sel < 60) begin
				// powers of the radix and one below them
				p = 1;
				repeat ($urandom_range(31, 1))
					if (p * r <= VALUE_MAX) p = p * r;
				v = $urandom_range(1) ? VALUE_BITS'(p) : VALUE_BITS'(p - 1);
			end
			add_req(v, r);
		end
		reqs_total = req_queue.size();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain: all requests taken and every digit seen
		while (req_queue.size() > 0 || in_valid || expected_digits.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_digits.size() > 0)
			report_mismatch($sformatf("%0d results never arrived", expected_digits.size()));

		if (mismatches == 0) begin
			$display("radix_digit_converter_tb passed");
		end else begin
			$display("radix_digit_converter_tb failed");
		end
		$finish;
	end

endmodule
